>>> design/table_sine_cosine_interp_macros.svh
`ifndef TABLE_SINE_COSINE_INTERP_MACROS_SVH
`define TABLE_SINE_COSINE_INTERP_MACROS_SVH

// Same-cycle implication on i_clk, off while i_rst_n is low
`define TSCI_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, off while i_rst_n is low
`define TSCI_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tsci_pkg.sv
package tsci_pkg;

    localparam int TABLE_SIZE    = 1024;
    localparam int FRACTION_BITS = 16;
    localparam int ANGLE_W       = 32;
    localparam int VALUE_W       = 18;

    localparam logic CMD_SIN = 1'b0;
    localparam logic CMD_COS = 1'b1;

    // pi in Q62
    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
    localparam logic [63:0] PI_FB   = ((PI_Q62 >> (61 - FRACTION_BITS)) + 64'd1) >> 1;
    localparam logic [63:0] HALF_PI = PI_FB / 64'd2;
    localparam logic [63:0] TWO_PI  = PI_FB * 64'd2;
    localparam logic [63:0] N1      = 64'(TABLE_SIZE - 1);

    // Bias that makes every wrapped angle non-negative, a multiple of 2pi
    localparam logic [63:0] OFFSET = ((64'd2147483648 + TWO_PI - 64'd1) / TWO_PI) * TWO_PI;
    localparam logic [63:0] X_MAX  = 64'd2147483647 + HALF_PI + OFFSET;
    localparam int XW              = $clog2(X_MAX + 64'd1);
    localparam logic [63:0] RECIP_X = (64'd1 << XW) / TWO_PI;
    localparam int RXW             = $clog2(RECIP_X + 64'd1);
    localparam logic [63:0] Q_MAX  = X_MAX / TWO_PI;
    localparam int QW              = $clog2(Q_MAX + 64'd1);
    localparam int MODW            = $clog2(TWO_PI * 64'd2);
    localparam int TW              = $clog2(TWO_PI);
    localparam int MW              = $clog2(HALF_PI + 64'd1);

    // Table position p = m * (TABLE_SIZE-1), split by HALF_PI
    localparam logic [63:0] P_MAX   = HALF_PI * N1;
    localparam int PW               = $clog2(P_MAX + 64'd1);
    localparam logic [63:0] RECIP_P = (64'd1 << PW) / HALF_PI;
    localparam int RPW              = $clog2(RECIP_P + 64'd1);
    localparam int IW               = $clog2(TABLE_SIZE);
    localparam logic [63:0] RECIP_F = (64'd1 << (MW + FRACTION_BITS)) / HALF_PI;
    localparam int RFW              = $clog2(RECIP_F + 64'd1);

    localparam int SW = FRACTION_BITS + 1;
    localparam int RW = (SW + 1 > VALUE_W) ? SW + 1 : VALUE_W;

    localparam int FRONT_STAGES = 5;
    localparam int QAW          = 3;
    localparam int QDEPTH       = 1 << QAW;
    localparam int QCW          = QAW + 1;

    typedef struct packed {
        logic          neg;
        logic [MW-1:0] m;
    } t_item;

    typedef struct packed {
        logic           empty;
        logic [QCW-1:0] count;
    } t_qstat;

    typedef logic [TABLE_SIZE-1:0][SW-1:0] t_rom;

    // (a * b) >> 60
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[123:60];
    endfunction

    // Shift-and-subtract quotient of num by den
    function automatic logic [63:0] udiv_q(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Taylor series of sine, Q60 in and out
    function automatic logic [63:0] sin_q60(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] den;
        logic        done;
        t2   = mul_q60(t, t);
        term = t;
        sum  = t;
        done = 1'b0;
        for (int k = 1; k <= 20; k++) begin
            if (!done) begin
                den  = 64'(2 * k) * 64'(2 * k + 1);
                term = udiv_q(mul_q60(term, t2), den);
                if (term == 64'd0) begin
                    done = 1'b1;
                end else if ((k & 1) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    function automatic logic [SW-1:0] rom_entry(input logic [63:0] i);
        logic [63:0] half;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] s;
        half = PI_Q62 >> 3;
        q    = half / N1;
        r    = half % N1;
        t    = q * i + (r * i) / N1;
        s    = sin_q60(t);
        return SW'(((s >> (59 - FRACTION_BITS)) + 64'd1) >> 1);
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            rom[i] = rom_entry(64'(i));
        end
        return rom;
    endfunction

endpackage

>>> design/tsci_front.sv
`include "table_sine_cosine_interp_macros.svh"

module tsci_front
    import tsci_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_cmd,
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  t_qstat                    i_qstat,
    output logic                      o_push,
    output t_item                     o_item
);

    logic [FRONT_STAGES:1] r_v;
    logic [XW-1:0]         r_x1;
    logic [XW-1:0]         r_x2;
    logic [QW-1:0]         r_q2;
    logic [MODW-1:0]       r_r3;
    logic [TW-1:0]         r_m4;
    t_item                 r_item5;

    logic [XW-1:0]         n_x1;
    logic [QW-1:0]         n_q2;
    logic [MODW-1:0]       n_r3;
    logic [TW-1:0]         n_m4;
    t_item                 n_item5;

    logic [XW+RXW-1:0]     q_prod;
    logic [QCW:0]          inflight;
    logic                  accept;
    logic                  le_h;
    logic                  le_pi;
    logic                  le_3h;

    // Hold off upstream unless every transaction in flight has a queue slot
    always_comb begin
        inflight = '0;
        for (int s = 1; s <= FRONT_STAGES; s++) begin
            inflight = inflight + (QCW + 1)'(r_v[s]);
        end
    end

    assign o_stall = ({1'b0, i_qstat.count} + inflight) >= (QCW + 1)'(QDEPTH);
    assign accept  = i_valid && !o_stall;

    assign n_x1 = {{(XW - ANGLE_W){i_angle[ANGLE_W-1]}}, i_angle} + XW'(OFFSET)
                + ((i_cmd == CMD_COS) ? XW'(HALF_PI) : XW'(0));

    // Quotient estimate by reciprocal, low by at most one
    assign q_prod = r_x1 * RXW'(RECIP_X);
    assign n_q2   = QW'(q_prod >> XW);
    assign n_r3   = MODW'(r_x2 - XW'(r_q2 * XW'(TWO_PI)));
    assign n_m4   = (r_r3 >= MODW'(TWO_PI)) ? TW'(r_r3 - MODW'(TWO_PI)) : TW'(r_r3);

    // Fold into the first quadrant; negate in the lower half-turn
    always_comb begin
        le_h  = r_m4 <= TW'(HALF_PI);
        le_pi = r_m4 <= TW'(PI_FB);
        le_3h = r_m4 <= TW'(PI_FB + HALF_PI);
        n_item5.neg = !le_pi;
        if (le_h) begin
            n_item5.m = MW'(r_m4);
        end else if (le_pi) begin
            n_item5.m = MW'(TW'(PI_FB) - r_m4);
        end else if (le_3h) begin
            n_item5.m = MW'(r_m4 - TW'(PI_FB));
        end else begin
            n_item5.m = MW'((TW + 1)'(TWO_PI) - (TW + 1)'(r_m4));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[FRONT_STAGES-1:1], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1    <= n_x1;
        r_x2    <= r_x1;
        r_q2    <= n_q2;
        r_r3    <= n_r3;
        r_m4    <= n_m4;
        r_item5 <= n_item5;
    end

    assign o_push = r_v[FRONT_STAGES];
    assign o_item = r_item5;

    `TSCI_ASSERT_NOW(a_wrap_one_step, r_v[3], r_r3 < MODW'(TWO_PI * 64'd2), "wrap estimate off by more than one")

endmodule

>>> design/tsci_queue.sv
`include "table_sine_cosine_interp_macros.svh"

module tsci_queue
    import tsci_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_item,
    output t_qstat o_qstat
);

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_count;
    logic [QCW-1:0] n_count;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item        = r_mem[r_rd];
    assign o_qstat.count = r_count;
    assign o_qstat.empty = (r_count == '0);

    `TSCI_ASSERT_NOW(a_no_overflow, i_push, r_count < QCW'(QDEPTH), "push into full queue")
    `TSCI_ASSERT_NOW(a_no_underflow, i_pop, r_count != '0, "pop from empty queue")
    `TSCI_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count lost a push")

endmodule

>>> design/tsci_back.sv
`include "table_sine_cosine_interp_macros.svh"

module tsci_back
    import tsci_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_qstat                    i_qstat,
    input  t_item                     i_item,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [VALUE_W-1:0] o_value
);

    localparam t_rom SINE_ROM = build_rom();

    logic [9:1]                r_v;
    logic [8:1]                r_neg;
    logic [PW-1:0]             r_p1;
    logic [PW-1:0]             r_p2;
    logic [IW-1:0]             r_idx2;
    logic [IW-1:0]             r_idx3;
    logic [MW:0]               r_rem3;
    logic [IW-1:0]             r_idx4;
    logic [IW-1:0]             r_idx4b;
    logic [MW-1:0]             r_rem4;
    logic [SW-1:0]             r_s05;
    logic [SW-1:0]             r_s15;
    logic [FRACTION_BITS-1:0]  r_fe5;
    logic [MW-1:0]             r_rem5;
    logic [SW-1:0]             r_s06;
    logic [SW-1:0]             r_diff6;
    logic [FRACTION_BITS-1:0]  r_fe6;
    logic [MW:0]               r_fr6;
    logic [SW-1:0]             r_s07;
    logic [SW-1:0]             r_diff7;
    logic [FRACTION_BITS-1:0]  r_frac7;
    logic [SW-1:0]             r_s08;
    logic [SW+FRACTION_BITS-1:0] r_prod8;
    logic signed [VALUE_W-1:0] r_value9;

    logic [PW+RPW-1:0]         idx_prod;
    logic                      rem_ge;
    logic [IW-1:0]             n_idx4;
    logic [IW-1:0]             n_idx4b;
    logic [MW-1:0]             n_rem4;
    logic [MW+RFW-1:0]         frac_prod;
    logic [MW+FRACTION_BITS-1:0] frac_num;
    logic [SW-1:0]             mag;
    logic [RW-1:0]             res;
    logic                      adv;

    // Advance the whole pipe unless the result register is held
    assign adv   = !(r_v[9] && i_stall);
    assign o_pop = adv && !i_qstat.empty;

    assign idx_prod = r_p1 * RPW'(RECIP_P);

    // Correct the index estimate and pick the upper neighbor, clamped at the end
    always_comb begin
        rem_ge = r_rem3 >= (MW + 1)'(HALF_PI);
        if (rem_ge) begin
            n_idx4  = r_idx3 + 1'b1;
            n_idx4b = r_idx3 + IW'(2);
            n_rem4  = MW'(r_rem3 - (MW + 1)'(HALF_PI));
        end else begin
            n_idx4  = r_idx3;
            n_idx4b = r_idx3 + 1'b1;
            n_rem4  = MW'(r_rem3);
        end
        if (n_idx4 == IW'(N1)) begin
            n_idx4b = n_idx4;
        end
    end

    assign frac_prod = r_rem4 * RFW'(RECIP_F);
    assign frac_num  = {r_rem5, {FRACTION_BITS{1'b0}}};

    assign mag = r_s08 + SW'(r_prod8 >> FRACTION_BITS);
    assign res = r_neg[8] ? RW'(-RW'(mag)) : RW'(mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[8:1], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_neg    <= {r_neg[7:1], i_item.neg};
            r_p1     <= PW'(i_item.m * PW'(N1));
            r_p2     <= r_p1;
            r_idx2   <= IW'(idx_prod >> PW);
            r_idx3   <= r_idx2;
            r_rem3   <= (MW + 1)'(r_p2 - PW'(r_idx2 * PW'(HALF_PI)));
            r_idx4   <= n_idx4;
            r_idx4b  <= n_idx4b;
            r_rem4   <= n_rem4;
            r_s05    <= SINE_ROM[r_idx4];
            r_s15    <= SINE_ROM[r_idx4b];
            r_fe5    <= FRACTION_BITS'(frac_prod >> MW);
            r_rem5   <= r_rem4;
            r_s06    <= r_s05;
            r_diff6  <= (r_s15 > r_s05) ? SW'(r_s15 - r_s05) : '0;
            r_fe6    <= r_fe5;
            r_fr6    <= (MW + 1)'(frac_num
                        - (MW + FRACTION_BITS)'(r_fe5 * (MW + FRACTION_BITS)'(HALF_PI)));
            r_s07    <= r_s06;
            r_diff7  <= r_diff6;
            r_frac7  <= r_fe6 + FRACTION_BITS'(r_fr6 >= (MW + 1)'(HALF_PI));
            r_s08    <= r_s07;
            r_prod8  <= r_diff7 * r_frac7;
            r_value9 <= VALUE_W'(res);
        end
    end

    assign o_valid = r_v[9];
    assign o_value = r_value9;

    `TSCI_ASSERT_NOW(a_index_one_step, r_v[3], r_rem3 < (MW + 1)'(HALF_PI * 64'd2), "index estimate off by more than one")
    `TSCI_ASSERT_NOW(a_frac_one_step, r_v[6], r_fr6 < (MW + 1)'(HALF_PI * 64'd2), "fraction estimate off by more than one")

endmodule

>>> design/table_sine_cosine_interp.sv
// Sine or cosine of a fixed-point angle from a quarter-wave table with
// linear interpolation.
// Input channel: i_valid / o_stall with i_cmd (0 sine, 1 cosine) and
// i_angle (signed radians, 16 fraction bits). A transaction is taken at a
// rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_value (signed, 16 fraction bits).
// Throughput: one transaction per cycle while the receiver does not
// stall; every stage is pipelined and the 8-entry queue between the angle
// reduction front (5 stages) and the table back end (9 stages) covers
// the front's flight time. A transaction passes through the front, the
// queue and the back end to the output, held longer while i_stall is high.
// When i_stall holds a result, the back end freezes, the queue fills and
// o_stall rises once the queue plus the front stages would be full.
// Reset (i_rst_n low at a clock edge) empties the pipe and queue; the
// table is a constant ROM and needs no fill.
module table_sine_cosine_interp
    import tsci_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_cmd,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [VALUE_W-1:0] o_value
);

    logic   push;
    logic   pop;
    t_item  front_item;
    t_item  head_item;
    t_qstat qstat;

    tsci_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_cmd   (i_cmd),
        .i_angle (i_angle),
        .i_qstat (qstat),
        .o_push  (push),
        .o_item  (front_item)
    );

    tsci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_qstat (qstat)
    );

    tsci_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_item  (head_item),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_value (o_value)
    );

endmodule

>>> verif/table_sine_cosine_interp_check.sv
module table_sine_cosine_interp_check
    import tsci_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_cmd,
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [VALUE_W-1:0] i_value,
    output int                        o_errors,
    output int                        o_pending
);

    localparam logic [63:0] PI_Q62_BITS = 64'hC90FDAA22168C235;
    localparam longint      ANG_PI      = longint'(((PI_Q62_BITS >> (61 - FRACTION_BITS))
                                                    + 64'd1) >> 1);
    localparam longint      ANG_HALF_PI = ANG_PI / 2;
    localparam longint      ANG_TWO_PI  = ANG_PI * 2;
    localparam int          LAST        = TABLE_SIZE - 1;

    typedef struct {
        logic                      cmd;
        logic signed [ANGLE_W-1:0] angle;
        logic [VALUE_W-1:0]        value;
    } t_sine_result;

    longint       quarter_wave[TABLE_SIZE];
    t_sine_result sine_results[$];
    t_sine_result oldest;
    int           mismatch_count = 0;

    // (a * b) >> 60, both in Q60
    function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = {64'd0, a} * {64'd0, b};
        return 64'(wide >> 60);
    endfunction

    function automatic logic [63:0] taylor_sine(input logic [63:0] t);
        logic [63:0] t_sq;
        logic [63:0] term;
        logic [63:0] acc;
        t_sq = q60_product(t, t);
        term = t;
        acc  = t;
        for (int k = 1; k <= 20; k++) begin
            term = q60_product(term, t_sq) / (64'(2 * k) * 64'(2 * k + 1));
            if (term == 64'd0)
                break;
            acc = (k % 2 == 1) ? acc - term : acc + term;
        end
        return acc;
    endfunction

    // sine at i / LAST of a quarter turn, rounded to FRACTION_BITS
    function automatic longint quarter_sample(input int i);
        logic [63:0] quarter;
        logic [63:0] step;
        logic [63:0] spill;
        logic [63:0] arg;
        logic [63:0] s;
        quarter = PI_Q62_BITS >> 3;
        step    = quarter / 64'(LAST);
        spill   = quarter % 64'(LAST);
        arg     = step * 64'(i) + (spill * 64'(i)) / 64'(LAST);
        s       = taylor_sine(arg);
        return longint'(((s >> (59 - FRACTION_BITS)) + 64'd1) >> 1);
    endfunction

    function automatic logic [VALUE_W-1:0] sine_of(input logic cmd,
                                                   input logic signed [ANGLE_W-1:0] angle);
        longint      wrapped;
        longint      lo;
        longint      hi;
        longint      level;
        logic [63:0] pos;
        logic [63:0] idx;
        logic [63:0] rem;
        logic [63:0] frac;
        logic        flip;
        wrapped = longint'(angle);
        if (cmd == CMD_COS)
            wrapped = wrapped + ANG_HALF_PI;
        // floored modulo into [0, 2pi)
        wrapped = wrapped % ANG_TWO_PI;
        if (wrapped < 0)
            wrapped = wrapped + ANG_TWO_PI;
        flip = 1'b0;
        if (wrapped > ANG_PI) begin
            flip    = 1'b1;
            wrapped = wrapped - ANG_PI;
        end
        if (wrapped > ANG_HALF_PI)
            wrapped = ANG_PI - wrapped;
        pos = 64'(wrapped) * 64'(LAST);
        idx = pos / 64'(ANG_HALF_PI);
        rem = pos % 64'(ANG_HALF_PI);
        // exactly a quarter turn: take the last entry, read nothing past it
        if (idx >= 64'(LAST)) begin
            level = quarter_wave[LAST];
        end else begin
            frac = (rem << FRACTION_BITS) / 64'(ANG_HALF_PI);
            lo   = quarter_wave[int'(idx)];
            hi   = quarter_wave[int'(idx) + 1];
            if (hi < lo)
                hi = lo;
            level = lo + longint'((64'(hi - lo) * frac) >> FRACTION_BITS);
        end
        if (flip)
            level = -level;
        return VALUE_W'(level);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 200)
            $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    initial begin
        for (int i = 0; i < TABLE_SIZE; i++)
            quarter_wave[i] = quarter_sample(i);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sine_results.delete();
            o_pending <= 0;
            o_errors  <= mismatch_count;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (sine_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no transaction outstanding",
                                              i_value));
                end else begin
                    oldest = sine_results.pop_front();
                    if (i_value !== oldest.value)
                        report_mismatch($sformatf("cmd %0d angle %0d: value %0d, want %0d",
                                                  oldest.cmd, oldest.angle, i_value,
                                                  $signed(oldest.value)));
                end
            end
            if (i_in_valid && !i_in_stall)
                sine_results.push_back('{i_cmd, i_angle, sine_of(i_cmd, i_angle)});
            o_pending <= sine_results.size();
            o_errors  <= mismatch_count;
        end
    end

endmodule

>>> verif/table_sine_cosine_interp_test.sv
module table_sine_cosine_interp_test;
    import tsci_pkg::*;

    localparam longint Q_HALF = longint'(HALF_PI);
    localparam longint Q_PI   = longint'(PI_FB);
    localparam longint Q_TWO  = longint'(TWO_PI);

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      i_cmd   = CMD_SIN;
    logic signed [ANGLE_W-1:0] i_angle = '0;
    logic                      i_stall = 1'b0;
    logic                      o_stall;
    logic                      o_valid;
    logic signed [VALUE_W-1:0] o_value;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int errors;
    int outstanding;

    table_sine_cosine_interp i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_cmd  (i_cmd),
        .i_angle(i_angle),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_value(o_value)
    );

    table_sine_cosine_interp_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_stall (o_stall),
        .i_cmd      (i_cmd),
        .i_angle    (i_angle),
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_value    (o_value),
        .o_errors   (errors),
        .o_pending  (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_angle(input logic cmd, input longint angle);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_angle <= ANGLE_W'(angle);
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    function automatic longint random_angle();
        longint k;
        case ($urandom_range(5))
            0: return longint'($signed($urandom));
            // near a multiple of a quarter turn, where the folding switches
            1: begin
                k = longint'($urandom_range(80)) - 40;
                return k * Q_HALF + longint'($urandom_range(16)) - 8;
            end
            2: return longint'($urandom_range(8 * Q_TWO)) - 4 * Q_TWO;
            3: return longint'($urandom_range(131072)) - 65536;
            4: return $urandom_range(1) ? 64'sd2147483647 - longint'($urandom_range(1000))
                                        : -64'sd2147483648 + longint'($urandom_range(1000));
            default: return longint'($signed($urandom));
        endcase
    endfunction

    initial begin
        longint edge_angles[12];
        edge_angles = '{0, 1, Q_HALF - 1, Q_HALF, Q_HALF + 1, Q_PI, Q_PI + Q_HALF, Q_TWO,
                        -1, -Q_HALF, 64'sd2147483647, -64'sd2147483648};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (edge_angles[j]) begin
            send_angle(CMD_SIN, edge_angles[j]);
            send_angle(CMD_COS, edge_angles[j]);
        end

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 80; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 80; end
                default: begin send_idle_pct = 6; stall_pct <= 6; end
            endcase
            repeat (140)
                send_angle($urandom_range(1) ? CMD_COS : CMD_SIN, random_angle());
        end
        i_valid <= 1'b0;

        // drain, then let the pipe settle
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
